>>> rtl/ddo_pkg.sv
// shared constants and the cordic arctangent table for the odometry core
`default_nettype none
package ddo_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_METERS_PER_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING_PER_COUNT = 1'd1;

    localparam logic [31:0] METERS_PER_COUNT_RST  = 32'd1799063;
    localparam logic [31:0] HEADING_PER_COUNT_RST = 32'd854714;

    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IDX_W   = 5;

    localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;

    function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/diff_drive_odometry_core.sv
// differential drive wheel odometry core with a shared multiplier and iterative cordic
//
// input channel: i_in_valid / o_in_stall carries one transaction of cumulative right
// and left encoder counts. output channel: o_out_valid / i_out_stall carries the
// updated x/y position (Q16.16), the heading as a 16-bit binary angle and the step
// distance of that sample. configuration: i_cfg_we writes meters_per_count (index 0)
// or heading_per_count (index 1); the user must do so only while the core is idle,
// as the core itself does not enforce it.
// the first sample after reset becomes the zero reference and gives no motion.
// an accepted transaction runs through S_MUL_HD, S_HEAD, S_MUL_SD, S_ABS, S_SAT,
// CORDIC_STEPS cordic iterations at one per cycle, S_FIX, S_MUL_X, S_ACC_X, S_MUL_Y
// and S_ACC_Y to o_out_valid, with four passes through the single 33x33 multiplier.
// o_in_stall stays high from acceptance until the result is taken, so the core takes
// no new transaction before then; a stalling receiver holds the result meanwhile.
// synchronous active-low reset clears position, reference and the output valid,
// and loads the register defaults.
`default_nettype none
module diff_drive_odometry_core
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire  signed [31:0]          i_right_count,
    input  wire  signed [31:0]          i_left_count,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic signed [31:0]          o_pos_x,
    output logic signed [31:0]          o_pos_y,
    output logic signed [15:0]          o_heading,
    output logic signed [31:0]          o_step_distance,
    input  wire                         i_cfg_we,
    input  wire         [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire         [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_HD, S_HEAD, S_MUL_SD, S_ABS, S_SAT,
        S_CORDIC, S_FIX, S_MUL_X, S_ACC_X, S_MUL_Y, S_ACC_Y, S_OUT
    } t_state;

    localparam logic [ATAN_IDX_W-1:0] LAST_ITER = ATAN_IDX_W'(CORDIC_STEPS - 1);

    t_state r_state;
    logic [31:0] r_mpc, r_hpc;
    logic        r_seen_first;
    logic [31:0] r_ref_right, r_ref_left, r_prev_right, r_prev_left;
    logic signed [31:0] r_acc_x, r_acc_y;
    logic signed [32:0] r_sum;
    logic [31:0] r_diff;
    logic signed [65:0] r_prod;
    logic signed [15:0] r_hd;
    logic signed [31:0] r_sd;
    logic signed [32:0] r_cx, r_cy, r_cz;
    logic        r_fneg;
    logic [ATAN_IDX_W-1:0] r_iter;

    // combinational helpers
    logic [31:0] n_base_right, n_base_left, n_ref_right, n_ref_left;
    logic signed [32:0] n_sum;
    logic [31:0] n_diff;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [31:0] n_hround;
    logic signed [16:0] n_h, n_hf;
    logic        n_fneg;
    logic [65:0] n_qfull;
    logic [48:0] n_q;
    logic signed [31:0] n_sd;
    logic signed [32:0] n_xs, n_ys;
    logic signed [32:0] n_atan;
    logic signed [65:0] n_rnd;
    logic        in_acc, out_acc;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    always_comb begin
        n_base_right = r_seen_first ? r_prev_right : i_right_count;
        n_base_left  = r_seen_first ? r_prev_left  : i_left_count;
        n_ref_right  = r_seen_first ? r_ref_right  : i_right_count;
        n_ref_left   = r_seen_first ? r_ref_left   : i_left_count;
        n_sum = 33'(signed'(i_right_count - n_base_right))
              + 33'(signed'(i_left_count - n_base_left));
        n_diff = (i_left_count - n_ref_left) - (i_right_count - n_ref_right);
    end

    always_comb begin
        unique case (r_state)
            S_MUL_HD: begin
                mul_a = signed'({1'b0, r_diff});
                mul_b = signed'({1'b0, r_hpc});
            end
            S_MUL_SD: begin
                mul_a = r_sum;
                mul_b = signed'({1'b0, r_mpc});
            end
            S_MUL_X: begin
                mul_a = 33'(r_sd);
                mul_b = r_cx;
            end
            default: begin
                mul_a = 33'(r_sd);
                mul_b = r_cy;
            end
        endcase
        mul_p = 66'(mul_a) * 66'(mul_b);
    end

    always_comb begin
        n_hround = r_prod[31:0] + 32'h0000_8000;
        n_h = 17'(signed'(n_hround[31:16]));
        if (n_h > 17'sd16384) begin
            n_hf   = n_h - 17'sd32768;
            n_fneg = 1'b1;
        end else if (n_h < -17'sd16384) begin
            n_hf   = n_h + 17'sd32768;
            n_fneg = 1'b1;
        end else begin
            n_hf   = n_h;
            n_fneg = 1'b0;
        end
    end

    always_comb begin
        n_qfull = unsigned'(r_prod) + 66'd65536;
        n_q = n_qfull[65:17];
        if (!r_sum[32]) begin
            n_sd = (n_q > 49'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(n_q[31:0]);
        end else begin
            n_sd = (n_q > 49'h0_8000_0000) ? 32'sh8000_0000 : signed'(-n_q[31:0]);
        end
    end

    always_comb begin
        n_xs   = r_cx >>> r_iter;
        n_ys   = r_cy >>> r_iter;
        n_atan = signed'({1'b0, atan_turn(r_iter)});
        n_rnd  = r_prod + 66'sd536870912;
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = (r_state == S_OUT);
    assign o_pos_x         = r_acc_x;
    assign o_pos_y         = r_acc_y;
    assign o_heading       = r_hd;
    assign o_step_distance = r_sd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mpc        <= METERS_PER_COUNT_RST;
            r_hpc        <= HEADING_PER_COUNT_RST;
            r_seen_first <= 1'b0;
            r_ref_right  <= '0;
            r_ref_left   <= '0;
            r_prev_right <= '0;
            r_prev_left  <= '0;
            r_acc_x      <= '0;
            r_acc_y      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_METERS_PER_COUNT:  r_mpc <= i_cfg_data;
                    CFG_HEADING_PER_COUNT: r_hpc <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_seen_first <= 1'b1;
                        r_ref_right  <= n_ref_right;
                        r_ref_left   <= n_ref_left;
                        r_prev_right <= i_right_count;
                        r_prev_left  <= i_left_count;
                        r_sum        <= n_sum;
                        r_diff       <= n_diff;
                        r_state      <= S_MUL_HD;
                    end
                end
                S_MUL_HD: begin
                    r_prod  <= mul_p;
                    r_state <= S_HEAD;
                end
                S_HEAD: begin
                    r_hd    <= signed'(n_hround[31:16]);
                    r_fneg  <= n_fneg;
                    r_cx    <= CORDIC_GAIN_Q30;
                    r_cy    <= '0;
                    r_cz    <= signed'({n_hf, 16'h0000});
                    r_iter  <= '0;
                    r_state <= S_MUL_SD;
                end
                S_MUL_SD: begin
                    r_prod  <= mul_p;
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    r_prod  <= r_prod[65] ? -r_prod : r_prod;
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_sd    <= n_sd;
                    r_state <= S_CORDIC;
                end
                S_CORDIC: begin
                    if (!r_cz[32]) begin
                        r_cx <= r_cx - n_ys;
                        r_cy <= r_cy + n_xs;
                        r_cz <= r_cz - n_atan;
                    end else begin
                        r_cx <= r_cx + n_ys;
                        r_cy <= r_cy - n_xs;
                        r_cz <= r_cz + n_atan;
                    end
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == LAST_ITER) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    if (r_fneg) begin
                        r_cx <= -r_cx;
                        r_cy <= -r_cy;
                    end
                    r_state <= S_MUL_X;
                end
                S_MUL_X: begin
                    r_prod  <= mul_p;
                    r_state <= S_ACC_X;
                end
                S_ACC_X: begin
                    r_acc_x <= r_acc_x + signed'(n_rnd[61:30]);
                    r_state <= S_MUL_Y;
                end
                S_MUL_Y: begin
                    r_prod  <= mul_p;
                    r_state <= S_ACC_Y;
                end
                S_ACC_Y: begin
                    r_acc_y <= r_acc_y + signed'(n_rnd[61:30]);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_acc) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // no new sample while a result is pending
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while result pending");

    // an accepted sample starts the busy period
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (o_in_stall && !o_out_valid))
        else $error("core not busy after accepting a sample");

    // a taken result is not repeated
    a_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |=> !o_out_valid)
        else $error("result repeated");

    // position only moves inside the accumulate steps
    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> ($stable(r_acc_x) && $stable(r_acc_y)))
        else $error("position changed while result held");

endmodule
`default_nettype wire

>>> test/ddo_checker.sv
// pose predictor and output checker for the odometry core testbench
module ddo_checker
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_in_stall,
    input  wire [31:0]           i_right_count,
    input  wire [31:0]           i_left_count,
    input  wire                  i_out_valid,
    input  wire                  i_out_stall,
    input  wire [31:0]           i_pos_x,
    input  wire [31:0]           i_pos_y,
    input  wire [15:0]           i_heading,
    input  wire [31:0]           i_step_distance,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [15:0] heading;
        logic [31:0] step_distance;
    } t_pose;

    t_pose       expected_poses[$];
    logic [31:0] meters_per_count;
    logic [31:0] heading_per_count;
    logic        seen_first;
    logic [31:0] ref_right, ref_left, prev_right, prev_left;
    logic [31:0] acc_x, acc_y;
    int          fails = 0;
    int          reported = 0;

    function automatic longint arctan_turn(input int i);
        longint v;
        case (i)
            0:       v = 64'h20000000;
            1:       v = 64'h12E4051E;
            2:       v = 64'h09FB385B;
            3:       v = 64'h051111D4;
            4:       v = 64'h028B0D43;
            5:       v = 64'h0145D7E1;
            6:       v = 64'h00A2F61E;
            7:       v = 64'h00517C55;
            8:       v = 64'h0028BE53;
            9:       v = 64'h00145F2F;
            10:      v = 64'h000A2F98;
            11:      v = 64'h000517CC;
            12:      v = 64'h00028BE6;
            13:      v = 64'h000145F3;
            14:      v = 64'h0000A2FA;
            15:      v = 64'h0000517D;
            16:      v = 64'h000028BE;
            17:      v = 64'h0000145F;
            18:      v = 64'h00000A30;
            19:      v = 64'h00000518;
            20:      v = 64'h0000028C;
            21:      v = 64'h00000146;
            22:      v = 64'h000000A3;
            default: v = 64'h00000051;
        endcase
        return v;
    endfunction

    task automatic rotate_heading(input longint ang, output longint cosv, output longint sinv);
        longint x, y, z, xs, ys;
        bit     flip;
        flip = 1'b0;
        x = longint'(CORDIC_GAIN_Q30);
        y = 0;
        // fold into the right half plane, negate at the end
        if (ang > 16384) begin
            ang = ang - 32768;
            flip = 1'b1;
        end else if (ang < -16384) begin
            ang = ang + 32768;
            flip = 1'b1;
        end
        z = ang * 65536;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_turn(i);
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_turn(i);
            end
        end
        cosv = flip ? -x : x;
        sinv = flip ? -y : y;
    endtask

    task automatic advance_odometry(input logic [31:0] r, input logic [31:0] l,
                                    output t_pose pose);
        logic [31:0] dr, dl, hr, hl;
        logic [63:0] mag, q, lim, hprod;
        logic [15:0] hb;
        longint      sum, sd, diff, hd, c, s, incx, incy;
        if (!seen_first) begin
            seen_first = 1'b1;
            ref_right  = r;
            ref_left   = l;
            prev_right = r;
            prev_left  = l;
        end
        dr  = r - prev_right;
        dl  = l - prev_left;
        sum = longint'($signed(dr)) + longint'($signed(dl));
        mag = (sum < 0) ? 64'(-sum) : 64'(sum);
        q   = (mag * {32'd0, meters_per_count} + 64'd65536) >> 17;
        lim = (sum >= 0) ? 64'h7FFF_FFFF : 64'h8000_0000;
        if (q > lim)
            q = lim;
        sd = longint'(q);
        if (sum < 0)
            sd = -sd;
        hr    = r - ref_right;
        hl    = l - ref_left;
        diff  = longint'($signed(hl)) - longint'($signed(hr));
        hprod = 64'(diff) * {32'd0, heading_per_count} + 64'h8000;
        hb    = hprod[31:16];
        hd    = longint'($signed(hb));
        rotate_heading(hd, c, s);
        incx  = (sd * c + (longint'(1) <<< 29)) >>> 30;
        incy  = (sd * s + (longint'(1) <<< 29)) >>> 30;
        acc_x = acc_x + 32'(incx);
        acc_y = acc_y + 32'(incy);
        prev_right = r;
        prev_left  = l;
        pose.pos_x         = acc_x;
        pose.pos_y         = acc_y;
        pose.heading       = hb;
        pose.step_distance = 32'(sd);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            fails++;
            if (reported < 10)
                $display("mismatch on %s: expected %h, got %h", name, want, got);
            reported++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pose want;
        if (!i_rst_n) begin
            meters_per_count  = METERS_PER_COUNT_RST;
            heading_per_count = HEADING_PER_COUNT_RST;
            seen_first = 1'b0;
            ref_right  = '0;
            ref_left   = '0;
            prev_right = '0;
            prev_left  = '0;
            acc_x      = '0;
            acc_y      = '0;
            expected_poses.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_METERS_PER_COUNT)
                    meters_per_count = i_cfg_data;
                else if (i_cfg_idx == CFG_HEADING_PER_COUNT)
                    heading_per_count = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_poses.size() == 0) begin
                    fails++;
                    if (reported < 10)
                        $display("output transaction with no pose expected: x %h y %h",
                                 i_pos_x, i_pos_y);
                    reported++;
                end else begin
                    want = expected_poses.pop_front();
                    compare_field("pos_x", want.pos_x, i_pos_x);
                    compare_field("pos_y", want.pos_y, i_pos_y);
                    compare_field("heading", {16'd0, want.heading}, {16'd0, i_heading});
                    compare_field("step_distance", want.step_distance, i_step_distance);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_odometry(i_right_count, i_left_count, want);
                expected_poses.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_poses.size();
    end

endmodule

>>> test/diff_drive_odometry_core_tb.sv
// testbench top for the odometry core: stimulus, idle patterns and final verdict
module diff_drive_odometry_core_tb;
    import ddo_pkg::*;

    localparam int          CORDIC_STEPS = 16;
    localparam logic [31:0] FIRST_RIGHT  = 32'h7FFF_FFFF;
    localparam logic [31:0] FIRST_LEFT   = 32'h8000_0000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [31:0]           right_count = '0;
    logic [31:0]           left_count = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic signed [31:0]    pos_x, pos_y, step_distance;
    logic signed [15:0]    heading;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = CFG_METERS_PER_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count, pending;

    int          src_idle_pct = 12;
    int          sink_stall_pct = 52;
    int          n_sent = 0;
    int          n_settings = 0;
    logic [31:0] cur_r, cur_l;

    diff_drive_odometry_core #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_right_count  (right_count),
        .i_left_count   (left_count),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_pos_x        (pos_x),
        .o_pos_y        (pos_y),
        .o_heading      (heading),
        .o_step_distance(step_distance),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data)
    );

    ddo_checker #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_right_count  (right_count),
        .i_left_count   (left_count),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_pos_x        (pos_x),
        .i_pos_y        (pos_y),
        .i_heading      (heading),
        .i_step_distance(step_distance),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    task automatic send_counts(input logic [31:0] r, input logic [31:0] l);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        right_count <= r;
        left_count  <= l;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (32) @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] mpc, input logic [31:0] hpc);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_METERS_PER_COUNT;
        cfg_data <= mpc;
        @(posedge clk);
        cfg_idx  <= CFG_HEADING_PER_COUNT;
        cfg_data <= hpc;
        @(posedge clk);
        cfg_we   <= 1'b0;
        n_settings++;
    endtask

    initial begin
        int sel;
        int heading_targets[11];
        heading_targets = '{0, 8192, 16384, 16385, -16384, -16385,
                            32767, 32768, -32767, -32768, 70000};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: reference, wrap and saturation cases
        send_counts(FIRST_RIGHT, FIRST_LEFT);
        send_counts(32'h8000_0000, 32'h7FFF_FFFF);
        send_counts(32'h8000_0010, 32'h8000_0020);
        send_counts(32'h8000_0010, 32'h8000_0020);
        send_counts(32'hC000_0010, 32'hC000_0020);
        send_counts(32'h4000_000F, 32'h4000_001F);
        send_counts(32'hC000_000F, 32'hC000_001F);
        send_counts(32'h0000_0000, 32'h0000_0000);
        send_counts(32'hFFFF_FFFF, 32'h0000_0001);
        drain();

        // unit heading gain so the wheel difference lands on the quadrant edges
        set_config(32'h0100_0000, 32'h0001_0000);
        cur_r = 32'h1234_5678;
        foreach (heading_targets[t]) begin
            cur_l = FIRST_LEFT + (cur_r - FIRST_RIGHT) + 32'(heading_targets[t]);
            send_counts(cur_r, cur_l);
        end
        drain();

        for (int k = 0; k < 6; k++) begin
            case (k / 2)
                0: begin
                    src_idle_pct   = 12;
                    sink_stall_pct = 52;
                end
                1: begin
                    src_idle_pct   = 52;
                    sink_stall_pct = 12;
                end
                default: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
            endcase
            case (k)
                0:       set_config(METERS_PER_COUNT_RST, HEADING_PER_COUNT_RST);
                1:       set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
                2:       set_config(32'h0000_0000, 32'h0000_0000);
                3:       set_config($urandom, $urandom);
                4:       set_config($urandom_range(1, 32'h0100_0000), $urandom);
                default: set_config($urandom, $urandom_range(0, 32'h0010_0000));
            endcase
            repeat (175) begin
                sel = $urandom_range(99);
                if (sel < 60) begin
                    cur_r = cur_r + 32'($urandom_range(2000)) - 32'd1000;
                    cur_l = cur_l + 32'($urandom_range(2000)) - 32'd1000;
                end else if (sel < 85) begin
                    cur_r = cur_r + ($urandom & 32'h000F_FFFF) - 32'h0008_0000;
                    cur_l = cur_l + ($urandom & 32'h000F_FFFF) - 32'h0008_0000;
                end else begin
                    cur_r = $urandom;
                    cur_l = $urandom;
                end
                send_counts(cur_r, cur_l);
            end
            drain();
        end

        $display("covered %0d transactions under %0d register settings", n_sent, n_settings);
        $display("traffic ran with an idling sender, a stalling receiver and back to back");
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #5000000;
        $display("timeout waiting for the core");
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/ddo_pkg.sv
rtl/diff_drive_odometry_core.sv
test/ddo_checker.sv
test/diff_drive_odometry_core_tb.sv
